>>> hw/rtl/sgrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrg_pkg: shared types and constants of the scaled glyph rectangle generator
// Beat layouts of the request, rectangle and register write channels, and the
// 8x8 font ROM.
// ----------------------------------------------------------------------------
package sgrg_pkg;

  // field widths
  localparam int COORD_WIDTH = 12;
  localparam int SCALE_WIDTH = 8;
  localparam int CODE_WIDTH  = 7;

  // glyph geometry
  localparam int GLYPH_SIZE = 8;
  localparam int GLYPH_BITS = GLYPH_SIZE * GLYPH_SIZE;
  localparam int COL_WIDTH  = $clog2(GLYPH_SIZE);
  localparam int SPAN_SHIFT = $clog2(GLYPH_SIZE);

  // width of the shared adder: coordinate plus a full glyph span
  localparam int SPAN_WIDTH = SCALE_WIDTH + SPAN_SHIFT;
  localparam int SUM_WIDTH  =
    ((COORD_WIDTH > SPAN_WIDTH) ? COORD_WIDTH : SPAN_WIDTH) + 1;

  // register write port
  localparam int CFG_IDX_WIDTH = 2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SCREEN_WIDTH  = CFG_IDX_WIDTH'(0);
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SCREEN_HEIGHT = CFG_IDX_WIDTH'(1);

  localparam logic [COORD_WIDTH-1:0] SCREEN_WIDTH_RST  = COORD_WIDTH'(1448);
  localparam logic [COORD_WIDTH-1:0] SCREEN_HEIGHT_RST = COORD_WIDTH'(1072);

  // operation codes
  localparam logic OP_SET    = 1'b0;
  localparam logic OP_TOGGLE = 1'b1;

  typedef struct packed {
    logic                   operation;
    logic [CODE_WIDTH-1:0]  char_code;
    logic [COORD_WIDTH-1:0] origin_x;
    logic [COORD_WIDTH-1:0] origin_y;
    logic [SCALE_WIDTH-1:0] scale;
    logic                   pixel_value;
  } sgrg_req_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] rect_x;
    logic [COORD_WIDTH-1:0] rect_y;
    logic [SCALE_WIDTH-1:0] rect_side;
    logic                   toggle_mode;
    logic                   paint_value;
    logic                   out_of_bounds;
    logic                   last;
  } sgrg_rect_t;

  typedef struct packed {
    logic [CFG_IDX_WIDTH-1:0] reg_index;
    logic [COORD_WIDTH-1:0]   wdata;
  } sgrg_cfg_t;

  // font ROM: top row in the upper byte, left column in the msb of a row
  function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [CODE_WIDTH-1:0] code);
    logic [63:0] g;
    case (code)
      7'd33:   g = 64'h1010_1010_1000_1000;
      7'd34:   g = 64'h2424_2400_0000_0000;
      7'd35:   g = 64'h2424_7E24_7E24_2400;
      7'd36:   g = 64'h103C_503C_143C_1000;
      7'd37:   g = 64'h6264_0810_2046_8600;
      7'd38:   g = 64'h3048_304A_4444_3A00;
      7'd39:   g = 64'h1010_2000_0000_0000;
      7'd40:   g = 64'h0810_2020_2010_0800;
      7'd41:   g = 64'h2010_0808_0810_2000;
      7'd42:   g = 64'h0024_187E_1824_0000;
      7'd43:   g = 64'h0010_107C_1010_0000;
      7'd44:   g = 64'h0000_0030_3010_2000;
      7'd45:   g = 64'h0000_007C_0000_0000;
      7'd46:   g = 64'h0000_0000_0030_3000;
      7'd47:   g = 64'h0204_0810_2040_0000;
      7'd48:   g = 64'h3C42_464A_5262_423C;
      7'd49:   g = 64'h1828_4808_0808_087E;
      7'd50:   g = 64'h3C42_020C_3040_407E;
      7'd51:   g = 64'h3C42_021C_0202_423C;
      7'd52:   g = 64'h040C_1424_447E_0404;
      7'd53:   g = 64'h7E40_407C_0202_423C;
      7'd54:   g = 64'h3C42_407C_4242_423C;
      7'd55:   g = 64'h7E02_0408_1020_2020;
      7'd56:   g = 64'h3C42_423C_4242_423C;
      7'd57:   g = 64'h3C42_4242_3E02_423C;
      7'd58:   g = 64'h0030_3000_3030_0000;
      7'd59:   g = 64'h0030_3000_3010_2000;
      7'd60:   g = 64'h0C10_2040_2010_0C00;
      7'd61:   g = 64'h007C_007C_0000_0000;
      7'd62:   g = 64'h6010_0804_0810_6000;
      7'd63:   g = 64'h3C42_020C_1000_1000;
      7'd64:   g = 64'h3C42_4E52_5E40_3C00;
      7'd65:   g = 64'h3C42_427E_4242_4200;
      7'd66:   g = 64'h7C42_427C_4242_427C;
      7'd67:   g = 64'h3C42_4040_4040_423C;
      7'd68:   g = 64'h7844_4242_4242_4478;
      7'd69:   g = 64'h7E40_407C_4040_407E;
      7'd70:   g = 64'h7E40_407C_4040_4040;
      7'd71:   g = 64'h3C42_4040_4E42_423C;
      7'd72:   g = 64'h4242_427E_4242_4200;
      7'd73:   g = 64'h3C10_1010_1010_103C;
      7'd74:   g = 64'h1E04_0404_0444_4438;
      7'd75:   g = 64'h4244_4870_4844_4200;
      7'd76:   g = 64'h4040_4040_4040_407E;
      7'd77:   g = 64'h4266_5A42_4242_4200;
      7'd78:   g = 64'h4262_524A_4642_4200;
      7'd79:   g = 64'h3C42_4242_4242_423C;
      7'd80:   g = 64'h7C42_427C_4040_4000;
      7'd81:   g = 64'h3C42_4242_4A44_3A00;
      7'd82:   g = 64'h7C42_427C_4844_4200;
      7'd83:   g = 64'h3C42_403C_0202_423C;
      7'd84:   g = 64'h7E10_1010_1010_1000;
      7'd85:   g = 64'h4242_4242_4242_423C;
      7'd86:   g = 64'h4242_4242_4224_1800;
      7'd87:   g = 64'h4242_425A_5A66_4200;
      7'd88:   g = 64'h4224_1818_1824_4200;
      7'd89:   g = 64'h4224_1810_1010_1000;
      7'd90:   g = 64'h7E02_0408_1020_407E;
      7'd91:   g = 64'h3C20_2020_2020_3C00;
      7'd92:   g = 64'h4020_1008_0402_0000;
      7'd93:   g = 64'h3C04_0404_0404_3C00;
      7'd94:   g = 64'h1028_4400_0000_0000;
      7'd95:   g = 64'h0000_0000_0000_00FF;
      7'd96:   g = 64'h2010_0800_0000_0000;
      7'd97:   g = 64'h003C_023E_4242_3E00;
      7'd98:   g = 64'h4040_5C62_4242_625C;
      7'd99:   g = 64'h003C_4240_4042_3C00;
      7'd100:  g = 64'h0202_3A46_4242_463A;
      7'd101:  g = 64'h003C_427E_4042_3C00;
      7'd102:  g = 64'h1C22_207C_2020_2000;
      7'd103:  g = 64'h003A_4642_423E_023C;
      7'd104:  g = 64'h4040_5C62_4242_4200;
      7'd105:  g = 64'h1000_3010_1010_3800;
      7'd106:  g = 64'h0400_0C04_0444_4438;
      7'd107:  g = 64'h4044_4870_4844_4200;
      7'd108:  g = 64'h3010_1010_1010_3800;
      7'd109:  g = 64'h006C_5252_5252_5200;
      7'd110:  g = 64'h005C_6242_4242_4200;
      7'd111:  g = 64'h003C_4242_4242_3C00;
      7'd112:  g = 64'h005C_6242_7C40_4000;
      7'd113:  g = 64'h003A_4642_3E02_0200;
      7'd114:  g = 64'h005C_6240_4040_4000;
      7'd115:  g = 64'h003E_403C_0242_3C00;
      7'd116:  g = 64'h2020_7C20_2022_1C00;
      7'd117:  g = 64'h0042_4242_4246_3A00;
      7'd118:  g = 64'h0042_4242_2424_1800;
      7'd119:  g = 64'h0042_425A_5A66_4200;
      7'd120:  g = 64'h0042_2418_1824_4200;
      7'd121:  g = 64'h0042_423E_0242_3C00;
      7'd122:  g = 64'h007E_0418_207E_0000;
      7'd123:  g = 64'h0C10_1060_1010_0C00;
      7'd124:  g = 64'h1010_1000_1010_1000;
      7'd125:  g = 64'h6010_100C_1010_6000;
      7'd126:  g = 64'h324C_0000_0000_0000;
      default: g = 64'h0000_0000_0000_0000;
    endcase
    return GLYPH_BITS'(g);
  endfunction

endpackage

>>> hw/rtl/sgrg_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgrg channel interfaces
// Valid/ready channels for draw requests, rectangle results and register
// writes.
// ----------------------------------------------------------------------------

// draw request channel
interface sgrg_req_if;
  logic                 valid;
  logic                 ready;
  sgrg_pkg::sgrg_req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// rectangle result channel
interface sgrg_rect_if;
  logic                 valid;
  logic                 ready;
  sgrg_pkg::sgrg_rect_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// register write channel
interface sgrg_cfg_if;
  logic                 valid;
  logic                 ready;
  sgrg_pkg::sgrg_cfg_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/scaled_glyph_rectangle_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_glyph_rectangle_generator_core: character to rectangle list
// Turns one draw request into one square rectangle per set pixel of the
// scaled 8x8 glyph, or into a single error beat when the cell leaves the screen or the scale is zero.
// ----------------------------------------------------------------------------
// Usage
//   in_req   : draw request beats (code, origin, scale, operation, value)
//   out_rect : rectangle beats, last set on the final beat of a request
//   cfg_wr   : register writes (screen width, screen height), always ready;
//              write only while no request is in flight
// Timing
//   A request passes the x and y bounds checks (CHKX, CHKY) on the shared adder,
//   then scans one glyph bit per cycle, waiting at a set bit while the output
//   register is held, up to the last set bit, and goes back to idle before the
//   next accept. The adder steps the x or y position once per scanned bit.
//   in_req is ready only while no request is being worked on; the last beat of
//   one request may still wait in the output register while the next is taken.
//   An error beat is loaded into the output register from the y check, once
//   that register is free; a blank in-bounds glyph gives no beat at all.
// Reset
//   Synchronous active-low reset empties the output register, returns to
//   idle and loads the screen size with 1448 x 1072.
// Stalls
//   A held output register freezes the scan at the next set bit.
// ----------------------------------------------------------------------------
module scaled_glyph_rectangle_generator_core (
  input  logic        clk,
  input  logic        rst_n,
  sgrg_req_if.sink    in_req,
  sgrg_rect_if.source out_rect,
  sgrg_cfg_if.sink    cfg_wr
);
  import sgrg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CHKX = 4'b0010,
    ST_CHKY = 4'b0100,
    ST_SCAN = 4'b1000
  } state_t;

  localparam logic [COL_WIDTH-1:0] COL_LAST = COL_WIDTH'(GLYPH_SIZE - 1);

  state_t                  state_r, state_nxt;
  logic                    tog_r, tog_nxt;
  logic                    val_r, val_nxt;
  logic [SCALE_WIDTH-1:0]  sc_r, sc_nxt;
  logic [COORD_WIDTH-1:0]  ox_r, ox_nxt;
  logic [COORD_WIDTH-1:0]  x_r, x_nxt;
  logic [COORD_WIDTH-1:0]  y_r, y_nxt;
  logic [GLYPH_BITS-1:0]   bits_r, bits_nxt;
  logic [COL_WIDTH-1:0]    col_r, col_nxt;
  logic                    oob_r, oob_nxt;
  logic [COORD_WIDTH-1:0]  width_r, height_r;
  sgrg_rect_t              out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    in_fire;
  logic                    slot_free;
  logic [SUM_WIDTH-1:0]    add_a, add_b, add_sum;
  logic [SPAN_WIDTH-1:0]   span;
  logic                    rest_zero;
  logic                    y_fail;

  assign in_req.ready   = (state_r == ST_IDLE);
  assign in_fire        = in_req.valid && in_req.ready;
  assign slot_free      = !out_valid_r || out_rect.ready;
  assign out_rect.valid = out_valid_r;
  assign out_rect.payload = out_r;
  assign cfg_wr.ready   = 1'b1;

  // shared adder: bounds sums during the check, position steps during the scan
  assign span = {sc_r, SPAN_SHIFT'(0)};
  always_comb begin
    case (state_r)
      ST_CHKX: begin
        add_a = SUM_WIDTH'(ox_r);
        add_b = SUM_WIDTH'(span);
      end
      ST_CHKY: begin
        add_a = SUM_WIDTH'(y_r);
        add_b = SUM_WIDTH'(span);
      end
      ST_SCAN: begin
        add_a = (col_r == COL_LAST) ? SUM_WIDTH'(y_r) : SUM_WIDTH'(x_r);
        add_b = SUM_WIDTH'(sc_r);
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end
  assign add_sum = add_a + add_b;

  assign rest_zero = (bits_r[GLYPH_BITS-2:0] == '0);
  assign y_fail    = oob_r || (add_sum >= SUM_WIDTH'(height_r));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    tog_nxt       = tog_r;
    val_nxt       = val_r;
    sc_nxt        = sc_r;
    ox_nxt        = ox_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    bits_nxt      = bits_r;
    col_nxt       = col_r;
    oob_nxt       = oob_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_rect.ready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          tog_nxt   = in_req.payload.operation;
          val_nxt   = (in_req.payload.operation == OP_TOGGLE) ? 1'b0
                                                              : in_req.payload.pixel_value;
          sc_nxt    = in_req.payload.scale;
          ox_nxt    = in_req.payload.origin_x;
          x_nxt     = in_req.payload.origin_x;
          y_nxt     = in_req.payload.origin_y;
          bits_nxt  = glyph_bits(in_req.payload.char_code);
          col_nxt   = '0;
          state_nxt = ST_CHKX;
        end
      end
      ST_CHKX: begin
        oob_nxt   = (sc_r == '0) || (add_sum >= SUM_WIDTH'(width_r));
        state_nxt = ST_CHKY;
      end
      ST_CHKY: begin
        if (y_fail) begin
          // error beat replaces the whole request
          if (slot_free) begin
            out_nxt       = '0;
            out_nxt.out_of_bounds = 1'b1;
            out_nxt.last  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (bits_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!bits_r[GLYPH_BITS-1] || slot_free) begin
          // emit on a set bit
          if (bits_r[GLYPH_BITS-1]) begin
            out_nxt.rect_x        = x_r;
            out_nxt.rect_y        = y_r;
            out_nxt.rect_side     = sc_r;
            out_nxt.toggle_mode   = tog_r;
            out_nxt.paint_value   = val_r;
            out_nxt.out_of_bounds = 1'b0;
            out_nxt.last          = rest_zero;
            out_valid_nxt         = 1'b1;
          end
          // step to the next column, wrap to the next row
          bits_nxt = {bits_r[GLYPH_BITS-2:0], 1'b0};
          col_nxt  = col_r + COL_WIDTH'(1);
          if (col_r == COL_LAST) begin
            x_nxt = ox_r;
            y_nxt = add_sum[COORD_WIDTH-1:0];
          end else begin
            x_nxt = add_sum[COORD_WIDTH-1:0];
          end
          if (rest_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      oob_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      oob_r       <= oob_nxt;
    end
  end

  // working and output payload registers
  always_ff @(posedge clk) begin
    tog_r  <= tog_nxt;
    val_r  <= val_nxt;
    sc_r   <= sc_nxt;
    ox_r   <= ox_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    bits_r <= bits_nxt;
    col_r  <= col_nxt;
    out_r  <= out_nxt;
  end

  // screen size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCREEN_WIDTH_RST;
      height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.payload.reg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_wr.payload.wdata;
        REG_SCREEN_HEIGHT: height_r <= cfg_wr.payload.wdata;
        default: ;
      endcase
    end
  end

  // error beats are always final and carry no rectangle
  a_err_beat : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.out_of_bounds) |-> (out_r.last && out_r.rect_side == '0))
    else $error("error beat without last or with a side");

  // rectangle beats carry the nonzero request scale
  a_rect_side : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.out_of_bounds) |-> (out_r.rect_side != '0))
    else $error("rectangle beat with zero side");

  // the scan only runs while set bits remain
  a_scan_bits : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (bits_r != '0))
    else $error("scan running on an empty glyph");

  // an accepted request always starts the bounds check
  a_accept_chk : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_CHKX))
    else $error("accepted request skipped the bounds check");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for scaled_glyph_rectangle_generator_core
// Draw requests come from a directed table and then from random phases under
// several screen sizes. A glyph predictor queues the expected rectangle beats,
// and each accepted rectangle beat is compared with the oldest one. Both
// channels idle at random, and a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module tb_top;
  import sgrg_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 8;
  // a blank glyph gives no beat; wait out its check cycles with a wide margin
  localparam int SETTLE_CYCLES  = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int IDLE_PCT       = 17;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_PHASES     = 6;
  localparam int NUM_ROWS       = 20;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_ERROR, ROW_SILENT} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    sgrg_req_t req;
  } dir_row_t;

  localparam sgrg_rect_t ERR_BEAT = '{rect_x: '0, rect_y: '0, rect_side: '0,
                                      toggle_mode: 1'b0, paint_value: 1'b0,
                                      out_of_bounds: 1'b1, last: 1'b1};

  logic clk;
  logic rst_n;

  sgrg_req_if  in_req();
  sgrg_rect_if out_rect();
  sgrg_cfg_if  cfg_wr();

  scaled_glyph_rectangle_generator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_rect (out_rect),
    .cfg_wr   (cfg_wr)
  );

  // glyph bitmaps: top row in the upper byte, left column in the msb
  logic [63:0]            font_rows [128];
  logic [COORD_WIDTH-1:0] scr_width;
  logic [COORD_WIDTH-1:0] scr_height;
  sgrg_rect_t             rect_expect_q [$];
  int unsigned            mismatch_count = 0;
  int unsigned            quiet_cycles = 0;
  bit                     no_idle = 1'b0;

  // directed requests, default screen 1448 x 1072
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{ROW_SILENT,  '{OP_SET,    7'd0,   12'd0,    12'd0,    8'd1,   1'b1}},
    '{ROW_SILENT,  '{OP_SET,    7'd127, 12'd1000, 12'd1000, 8'd4,   1'b0}},
    '{ROW_PREDICT, '{OP_SET,    7'd65,  12'd0,    12'd0,    8'd1,   1'b1}},
    '{ROW_PREDICT, '{OP_TOGGLE, 7'd65,  12'd0,    12'd0,    8'd1,   1'b1}},
    '{ROW_ERROR,   '{OP_SET,    7'd65,  12'd10,   12'd10,   8'd0,   1'b1}},
    '{ROW_ERROR,   '{OP_SET,    7'd72,  12'd0,    12'd0,    8'd255, 1'b1}},
    '{ROW_ERROR,   '{OP_SET,    7'd72,  12'd4095, 12'd0,    8'd1,   1'b1}},
    '{ROW_ERROR,   '{OP_TOGGLE, 7'd72,  12'd0,    12'd4095, 8'd1,   1'b0}},
    '{ROW_ERROR,   '{OP_SET,    7'd0,   12'd1440, 12'd0,    8'd1,   1'b1}},
    '{ROW_PREDICT, '{OP_SET,    7'd66,  12'd1439, 12'd0,    8'd1,   1'b1}},
    '{ROW_PREDICT, '{OP_TOGGLE, 7'd95,  12'd0,    12'd1063, 8'd1,   1'b0}},
    '{ROW_ERROR,   '{OP_SET,    7'd95,  12'd0,    12'd1064, 8'd1,   1'b1}},
    '{ROW_PREDICT, '{OP_SET,    7'd48,  12'd0,    12'd0,    8'd133, 1'b1}},
    '{ROW_ERROR,   '{OP_SET,    7'd48,  12'd0,    12'd0,    8'd134, 1'b0}},
    '{ROW_PREDICT, '{OP_SET,    7'd35,  12'd100,  12'd200,  8'd3,   1'b0}},
    '{ROW_PREDICT, '{OP_TOGGLE, 7'd126, 12'd777,  12'd333,  8'd5,   1'b1}},
    '{ROW_PREDICT, '{OP_SET,    7'd33,  12'd2,    12'd3,    8'd2,   1'b1}},
    '{ROW_PREDICT, '{OP_SET,    7'd37,  12'd1300, 12'd900,  8'd17,  1'b1}},
    '{ROW_ERROR,   '{OP_SET,    7'd127, 12'd4095, 12'd4095, 8'd255, 1'b1}},
    '{ROW_PREDICT, '{OP_SET,    7'd64,  12'd1,    12'd1,    8'd7,   1'b1}}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // font contents
  initial begin
    foreach (font_rows[i]) font_rows[i] = '0;
    font_rows[33]  = 64'h1010_1010_1000_1000;
    font_rows[34]  = 64'h2424_2400_0000_0000;
    font_rows[35]  = 64'h2424_7E24_7E24_2400;
    font_rows[36]  = 64'h103C_503C_143C_1000;
    font_rows[37]  = 64'h6264_0810_2046_8600;
    font_rows[38]  = 64'h3048_304A_4444_3A00;
    font_rows[39]  = 64'h1010_2000_0000_0000;
    font_rows[40]  = 64'h0810_2020_2010_0800;
    font_rows[41]  = 64'h2010_0808_0810_2000;
    font_rows[42]  = 64'h0024_187E_1824_0000;
    font_rows[43]  = 64'h0010_107C_1010_0000;
    font_rows[44]  = 64'h0000_0030_3010_2000;
    font_rows[45]  = 64'h0000_007C_0000_0000;
    font_rows[46]  = 64'h0000_0000_0030_3000;
    font_rows[47]  = 64'h0204_0810_2040_0000;
    font_rows[48]  = 64'h3C42_464A_5262_423C;
    font_rows[49]  = 64'h1828_4808_0808_087E;
    font_rows[50]  = 64'h3C42_020C_3040_407E;
    font_rows[51]  = 64'h3C42_021C_0202_423C;
    font_rows[52]  = 64'h040C_1424_447E_0404;
    font_rows[53]  = 64'h7E40_407C_0202_423C;
    font_rows[54]  = 64'h3C42_407C_4242_423C;
    font_rows[55]  = 64'h7E02_0408_1020_2020;
    font_rows[56]  = 64'h3C42_423C_4242_423C;
    font_rows[57]  = 64'h3C42_4242_3E02_423C;
    font_rows[58]  = 64'h0030_3000_3030_0000;
    font_rows[59]  = 64'h0030_3000_3010_2000;
    font_rows[60]  = 64'h0C10_2040_2010_0C00;
    font_rows[61]  = 64'h007C_007C_0000_0000;
    font_rows[62]  = 64'h6010_0804_0810_6000;
    font_rows[63]  = 64'h3C42_020C_1000_1000;
    font_rows[64]  = 64'h3C42_4E52_5E40_3C00;
    font_rows[65]  = 64'h3C42_427E_4242_4200;
    font_rows[66]  = 64'h7C42_427C_4242_427C;
    font_rows[67]  = 64'h3C42_4040_4040_423C;
    font_rows[68]  = 64'h7844_4242_4242_4478;
    font_rows[69]  = 64'h7E40_407C_4040_407E;
    font_rows[70]  = 64'h7E40_407C_4040_4040;
    font_rows[71]  = 64'h3C42_4040_4E42_423C;
    font_rows[72]  = 64'h4242_427E_4242_4200;
    font_rows[73]  = 64'h3C10_1010_1010_103C;
    font_rows[74]  = 64'h1E04_0404_0444_4438;
    font_rows[75]  = 64'h4244_4870_4844_4200;
    font_rows[76]  = 64'h4040_4040_4040_407E;
    font_rows[77]  = 64'h4266_5A42_4242_4200;
    font_rows[78]  = 64'h4262_524A_4642_4200;
    font_rows[79]  = 64'h3C42_4242_4242_423C;
    font_rows[80]  = 64'h7C42_427C_4040_4000;
    font_rows[81]  = 64'h3C42_4242_4A44_3A00;
    font_rows[82]  = 64'h7C42_427C_4844_4200;
    font_rows[83]  = 64'h3C42_403C_0202_423C;
    font_rows[84]  = 64'h7E10_1010_1010_1000;
    font_rows[85]  = 64'h4242_4242_4242_423C;
    font_rows[86]  = 64'h4242_4242_4224_1800;
    font_rows[87]  = 64'h4242_425A_5A66_4200;
    font_rows[88]  = 64'h4224_1818_1824_4200;
    font_rows[89]  = 64'h4224_1810_1010_1000;
    font_rows[90]  = 64'h7E02_0408_1020_407E;
    font_rows[91]  = 64'h3C20_2020_2020_3C00;
    font_rows[92]  = 64'h4020_1008_0402_0000;
    font_rows[93]  = 64'h3C04_0404_0404_3C00;
    font_rows[94]  = 64'h1028_4400_0000_0000;
    font_rows[95]  = 64'h0000_0000_0000_00FF;
    font_rows[96]  = 64'h2010_0800_0000_0000;
    font_rows[97]  = 64'h003C_023E_4242_3E00;
    font_rows[98]  = 64'h4040_5C62_4242_625C;
    font_rows[99]  = 64'h003C_4240_4042_3C00;
    font_rows[100] = 64'h0202_3A46_4242_463A;
    font_rows[101] = 64'h003C_427E_4042_3C00;
    font_rows[102] = 64'h1C22_207C_2020_2000;
    font_rows[103] = 64'h003A_4642_423E_023C;
    font_rows[104] = 64'h4040_5C62_4242_4200;
    font_rows[105] = 64'h1000_3010_1010_3800;
    font_rows[106] = 64'h0400_0C04_0444_4438;
    font_rows[107] = 64'h4044_4870_4844_4200;
    font_rows[108] = 64'h3010_1010_1010_3800;
    font_rows[109] = 64'h006C_5252_5252_5200;
    font_rows[110] = 64'h005C_6242_4242_4200;
    font_rows[111] = 64'h003C_4242_4242_3C00;
    font_rows[112] = 64'h005C_6242_7C40_4000;
    font_rows[113] = 64'h003A_4642_3E02_0200;
    font_rows[114] = 64'h005C_6240_4040_4000;
    font_rows[115] = 64'h003E_403C_0242_3C00;
    font_rows[116] = 64'h2020_7C20_2022_1C00;
    font_rows[117] = 64'h0042_4242_4246_3A00;
    font_rows[118] = 64'h0042_4242_2424_1800;
    font_rows[119] = 64'h0042_425A_5A66_4200;
    font_rows[120] = 64'h0042_2418_1824_4200;
    font_rows[121] = 64'h0042_423E_0242_3C00;
    font_rows[122] = 64'h007E_0418_207E_0000;
    font_rows[123] = 64'h0C10_1060_1010_0C00;
    font_rows[124] = 64'h1010_1000_1010_1000;
    font_rows[125] = 64'h6010_100C_1010_6000;
    font_rows[126] = 64'h324C_0000_0000_0000;
  end

  // expected rectangle beats of one accepted request
  function automatic void predict_rects(input sgrg_req_t r);
    int unsigned span;
    int unsigned n;
    int unsigned k;
    logic [63:0] g;
    sgrg_rect_t  b;
    span = GLYPH_SIZE * r.scale;
    if (r.scale == 0 || r.origin_x + span >= scr_width ||
        r.origin_y + span >= scr_height) begin
      rect_expect_q.push_back(ERR_BEAT);
      return;
    end
    g = font_rows[r.char_code];
    n = $countones(g);
    k = 0;
    // raster order, left column first; blank glyphs give nothing
    for (int row = 0; row < GLYPH_SIZE; row++) begin
      for (int col = 0; col < GLYPH_SIZE; col++) begin
        if (g[GLYPH_BITS - 1 - (row * GLYPH_SIZE + col)]) begin
          k++;
          b.rect_x        = COORD_WIDTH'(r.origin_x + col * r.scale);
          b.rect_y        = COORD_WIDTH'(r.origin_y + row * r.scale);
          b.rect_side     = r.scale;
          b.toggle_mode   = (r.operation == OP_TOGGLE);
          b.paint_value   = (r.operation == OP_TOGGLE) ? 1'b0 : r.pixel_value;
          b.out_of_bounds = 1'b0;
          b.last          = (k == n);
          rect_expect_q.push_back(b);
        end
      end
    end
  endfunction

  function automatic string rect_str(input sgrg_rect_t b);
    return $sformatf("x=%0d y=%0d side=%0d tog=%0b val=%0b oob=%0b last=%0b",
                     b.rect_x, b.rect_y, b.rect_side, b.toggle_mode,
                     b.paint_value, b.out_of_bounds, b.last);
  endfunction

  // compare one rectangle beat with the oldest expectation
  task automatic check_rect(input sgrg_rect_t got);
    sgrg_rect_t want;
    if (rect_expect_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: rect beat with nothing expected: %s", $realtime, rect_str(got));
      return;
    end
    want = rect_expect_q.pop_front();
    if (got.rect_x !== want.rect_x || got.rect_y !== want.rect_y ||
        got.rect_side !== want.rect_side || got.toggle_mode !== want.toggle_mode ||
        got.paint_value !== want.paint_value ||
        got.out_of_bounds !== want.out_of_bounds || got.last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%0t: rect beat mismatch", $realtime);
        $display("  expected %s", rect_str(want));
        $display("  actual   %s", rect_str(got));
      end
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_rect.valid && out_rect.ready) check_rect(out_rect.payload);
  end

  // receiver back-pressure
  initial begin
    out_rect.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_rect.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rect.valid && out_rect.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles", $realtime, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request beat; valid stays high on return so back-to-back beats flow
  task automatic send_req(input sgrg_req_t r, input row_kind_t kind);
    while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid   <= 1'b1;
    in_req.payload <= r;
    do @(posedge clk); while (!in_req.ready);
    case (kind)
      ROW_PREDICT: predict_rects(r);
      ROW_ERROR:   rect_expect_q.push_back(ERR_BEAT);
      ROW_SILENT:  ;
      default:     ;
    endcase
  endtask

  // stop requests, let every expected beat arrive, then cover a blank scan
  task automatic drain_all();
    in_req.valid <= 1'b0;
    while (rect_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [COORD_WIDTH-1:0]   value);
    @(posedge clk);
    cfg_wr.valid   <= 1'b1;
    cfg_wr.payload <= '{reg_index: idx, wdata: value};
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) scr_width = value;
    else if (idx == REG_SCREEN_HEIGHT) scr_height = value;
  endtask

  // main sequence
  initial begin
    int unsigned ph_width  [NUM_PHASES] = '{4095, 1, 4095, 9,    640, 0};
    int unsigned ph_height [NUM_PHASES] = '{4095, 1, 17,   4095, 480, 0};
    int unsigned ph_items  [NUM_PHASES] = '{110,  12, 40,  30,   80,  80};
    bit          ph_calm   [NUM_PHASES] = '{0,    0,  0,   0,    1,   0};
    int unsigned w;
    int unsigned h;
    int unsigned smax;
    int unsigned cap;
    sgrg_req_t   r;

    in_req.valid   <= 1'b0;
    in_req.payload <= '0;
    cfg_wr.valid   <= 1'b0;
    cfg_wr.payload <= '0;
    rst_n          <= 1'b0;
    scr_width  = SCREEN_WIDTH_RST;
    scr_height = SCREEN_HEIGHT_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table at the reset screen size
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].kind);

    // random phases, one screen size each
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_all();
      w = (ph_width[p] != 0) ? ph_width[p] : $urandom_range(4095, 1);
      h = (ph_height[p] != 0) ? ph_height[p] : $urandom_range(4095, 1);
      write_reg(REG_SCREEN_WIDTH, COORD_WIDTH'(w));
      write_reg(REG_SCREEN_HEIGHT, COORD_WIDTH'(h));
      no_idle = ph_calm[p];
      smax = ((scr_width < scr_height ? scr_width : scr_height) - 1) / GLYPH_SIZE;
      for (int k = 0; k < ph_items[p]; k++) begin
        r.operation   = 1'($urandom_range(1, 0));
        r.pixel_value = 1'($urandom_range(1, 0));
        if (smax == 0 || $urandom_range(99, 0) < 15) begin
          // noise: any field value, mostly off-screen
          r.char_code = CODE_WIDTH'($urandom_range(127, 0));
          r.origin_x  = COORD_WIDTH'($urandom_range(4095, 0));
          r.origin_y  = COORD_WIDTH'($urandom_range(4095, 0));
          r.scale     = SCALE_WIDTH'($urandom_range(255, 0));
        end else begin
          // cell that fits, mostly small magnification
          cap = (smax > 255) ? 255 : smax;
          if (cap > 8 && $urandom_range(99, 0) < 70) cap = 8;
          r.scale     = SCALE_WIDTH'($urandom_range(cap, 1));
          r.char_code = ($urandom_range(99, 0) < 85) ?
                        CODE_WIDTH'($urandom_range(126, 32)) :
                        CODE_WIDTH'($urandom_range(127, 0));
          r.origin_x  = COORD_WIDTH'($urandom_range(scr_width - 1 - GLYPH_SIZE * r.scale, 0));
          r.origin_y  = COORD_WIDTH'($urandom_range(scr_height - 1 - GLYPH_SIZE * r.scale, 0));
        end
        send_req(r, ROW_PREDICT);
      end
    end

    drain_all();
    if (mismatch_count == 0 && rect_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/sgrg_pkg.sv
hw/rtl/sgrg_ifs.sv
hw/rtl/scaled_glyph_rectangle_generator_core.sv
dv/tb_top.sv
